FILE: rtl/vtq_pkg.sv
// Shared types, constants and helper functions of the virtual-time task queue.
package vtq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS  = 8;
  localparam int KEY_W    = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CAPACITY-1:0] mask_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUPKEY   = 3'd4
  } status_t;

  // One queued task as held in a cell.
  typedef struct packed {
    logic valid;
    id_t  id;
    key_t tm;
    key_t sq;
    logic cancel;
  } entry_t;

  // Command operands broadcast to every cell.
  typedef struct packed {
    id_t  id;
    key_t tm;
    key_t sq;
  } req_t;

  // Per-cell update controls.
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
    logic set_cancel;
  } cell_ctrl_t;

  // Per-cell registered compare results.
  typedef struct packed {
    logic lt;     // new key precedes this task
    logic eq;     // same time and same sequence number
    logic match;  // same id
  } cell_flags_t;

  // Inclusive prefix OR from bit 0 upward, log-depth.
  function automatic mask_t prefix_or(input mask_t m);
    mask_t p;
    p = m;
    for (int k = 1; k < CAPACITY; k = k * 2) begin
      p = p | (p << k);
    end
    return p;
  endfunction

endpackage

FILE: rtl/vtq_in_if.sv
// Command channel: valid/ready handshake with the command payload.
interface vtq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [7:0]        task_id;
  vtq_pkg::key_t     key_time;
  vtq_pkg::key_t     key_seq;

  modport source (output valid, command, task_id, key_time, key_seq, input ready);
  modport sink   (input valid, command, task_id, key_time, key_seq, output ready);
endinterface

FILE: rtl/vtq_out_if.sv
// Result channel: valid/ready handshake with the result payload.
interface vtq_out_if;
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [7:0]    out_task_id;
  vtq_pkg::key_t out_time;
  vtq_pkg::key_t out_seq;
  logic          was_cancelled;
  logic          became_minimum;
  logic [6:0]    occupancy;

  modport source (output valid, status, out_task_id, out_time, out_seq, was_cancelled,
                  became_minimum, occupancy, input ready);
  modport sink   (input valid, status, out_task_id, out_time, out_seq, was_cancelled,
                  became_minimum, occupancy, output ready);
endinterface

FILE: rtl/virtual_time_task_queue_top.sv
// Virtual-time task queue: top level with command sequencer and a chain of task cells.
// A command is accepted, then compared, then applied, which registers its result.
// No new command is taken until apply; the apply step waits while a result is unread.
// The row of CAPACITY cells compares in parallel, then shifts one place left or right.
// Reset (synchronous, rst_n low): queue empty, occupancy 0, no result pending; no sweep.
module virtual_time_task_queue_top (
  input  logic      clk,
  input  logic      rst_n,
  vtq_in_if.sink    in_ch,
  vtq_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t               state_r;
  vtq_pkg::cmd_t        cmd_r;
  vtq_pkg::req_t        req_r;
  vtq_pkg::cnt_t        cnt_r;
  vtq_pkg::cnt_t        cnt_nxt;

  // Result register
  logic                 out_valid_r;
  vtq_pkg::status_t     status_r;
  vtq_pkg::status_t     status_nxt;
  vtq_pkg::id_t         oid_r;
  vtq_pkg::key_t        otime_r;
  vtq_pkg::key_t        oseq_r;
  logic                 ocancel_r;
  logic                 omin_r;
  logic                 omin_nxt;
  logic                 take_data;

  // Cell row
  vtq_pkg::entry_t      ent   [vtq_pkg::CAPACITY];
  vtq_pkg::cell_flags_t flags [vtq_pkg::CAPACITY];
  vtq_pkg::cell_ctrl_t  ctrl  [vtq_pkg::CAPACITY];
  vtq_pkg::cell_ctrl_t  ctrl_raw [vtq_pkg::CAPACITY];
  vtq_pkg::entry_t      rm_ent;

  vtq_pkg::mask_t       valid_v;
  vtq_pkg::mask_t       lt_v;
  vtq_pkg::mask_t       eq_v;
  vtq_pkg::mask_t       match_v;
  vtq_pkg::mask_t       ins_p;     // cells at or after the insertion place
  vtq_pkg::mask_t       ins_e;     // cells after the insertion place
  vtq_pkg::mask_t       rm_m;
  vtq_pkg::mask_t       rm_p;      // cells at or after the leaving task
  vtq_pkg::mask_t       rm_sel;    // one-hot: the leaving task
  logic                 full;
  logic                 dup;
  logic                 found;
  logic                 fire;

  assign in_ch.ready = (state_r == S_IDLE);

  // Apply only when the result register is free or being emptied this cycle.
  assign fire = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  // Gather per-cell state and flags into vectors.
  always_comb begin
    for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
      valid_v[i] = ent[i].valid;
      lt_v[i]    = flags[i].lt;
      eq_v[i]    = flags[i].eq;
      match_v[i] = flags[i].match;
    end
  end

  // Insertion place: first task the new key precedes, else the first empty cell.
  // Valid cells are packed from cell 0, so empty cells all lie past the tasks.
  always_comb begin
    full  = (cnt_r == vtq_pkg::cnt_t'(vtq_pkg::CAPACITY));
    dup   = |eq_v;
    ins_p = vtq_pkg::prefix_or(lt_v | ~valid_v);
    ins_e = ins_p << 1;
  end

  // Leaving task: cell 0 for pop, first id match for remove.
  always_comb begin
    if (cmd_r == vtq_pkg::CMD_POP) begin
      rm_m = vtq_pkg::mask_t'(valid_v[0]);
    end else begin
      rm_m = match_v;
    end
    found  = |rm_m;
    rm_p   = vtq_pkg::prefix_or(rm_m);
    rm_sel = rm_p & ~(rm_p << 1);
    rm_ent = '0;
    for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
      if (rm_sel[i]) begin
        rm_ent = rm_ent | ent[i];
      end
    end
  end

  // Decide the command's outcome and the cell moves.
  always_comb begin
    status_nxt = vtq_pkg::ST_OK;
    omin_nxt   = 1'b0;
    take_data  = 1'b0;
    cnt_nxt    = cnt_r;
    for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
      ctrl_raw[i] = '0;
    end
    case (cmd_r)
      vtq_pkg::CMD_PUSH: begin
        if (full) begin
          status_nxt = vtq_pkg::ST_FULL;
        end else if (dup) begin
          status_nxt = vtq_pkg::ST_DUPKEY;
        end else begin
          // Load at the insertion place, shift everything behind it right.
          for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
            ctrl_raw[i].load_new  = ins_p[i] & ~ins_e[i];
            ctrl_raw[i].take_left = ins_e[i];
          end
          omin_nxt = ins_p[0];
          cnt_nxt  = cnt_r + vtq_pkg::cnt_t'(1);
        end
      end
      vtq_pkg::CMD_POP, vtq_pkg::CMD_REMOVE: begin
        if (!found) begin
          status_nxt = (cmd_r == vtq_pkg::CMD_POP) ? vtq_pkg::ST_EMPTY
                                                   : vtq_pkg::ST_NOTFOUND;
        end else begin
          // Close the gap: the leaving cell and all behind it take from the right.
          for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
            ctrl_raw[i].take_right = rm_p[i];
          end
          take_data = 1'b1;
          cnt_nxt   = cnt_r - vtq_pkg::cnt_t'(1);
        end
      end
      vtq_pkg::CMD_CANCEL: begin
        for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
          ctrl_raw[i].set_cancel = 1'b1;
        end
      end
      default: begin
        status_nxt = vtq_pkg::ST_OK;
      end
    endcase
    for (int i = 0; i < vtq_pkg::CAPACITY; i++) begin
      ctrl[i] = fire ? ctrl_raw[i] : '0;
    end
  end

  // The chain of cells; each end sees an empty neighbor.
  for (genvar g = 0; g < vtq_pkg::CAPACITY; g++) begin : g_cell
    vtq_pkg::entry_t left_n;
    vtq_pkg::entry_t right_n;
    if (g == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid_l
      assign left_n = ent[g-1];
    end
    if (g == vtq_pkg::CAPACITY - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_mid_r
      assign right_n = ent[g+1];
    end
    vtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req_r),
      .ctrl      (ctrl[g]),
      .left_ent  (left_n),
      .right_ent (right_n),
      .ent       (ent[g]),
      .flags     (flags[g])
    );
  end

  // Sequencer: accept, compare, apply; hold the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken result unless a new one replaces it at this edge.
      if (out_valid_r && out_ch.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r    <= vtq_pkg::cmd_t'(in_ch.command);
            req_r.id <= vtq_pkg::id_t'(in_ch.task_id);
            req_r.tm <= in_ch.key_time;
            req_r.sq <= in_ch.key_seq;
            state_r  <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (fire) begin
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            omin_r      <= omin_nxt;
            oid_r       <= take_data ? rm_ent.id : '0;
            otime_r     <= take_data ? rm_ent.tm : '0;
            oseq_r      <= take_data ? rm_ent.sq : '0;
            ocancel_r   <= take_data & rm_ent.cancel;
            cnt_r       <= cnt_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.out_task_id    = 8'(oid_r);
  assign out_ch.out_time       = otime_r;
  assign out_ch.out_seq        = oseq_r;
  assign out_ch.was_cancelled  = ocancel_r;
  assign out_ch.became_minimum = omin_r;
  assign out_ch.occupancy      = 7'(cnt_r);

  // Occupancy tracks the number of occupied cells.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == int'(cnt_r))
    else $error("occupancy differs from occupied cells");

  // Occupied cells form an unbroken run from cell 0.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v + vtq_pkg::mask_t'(1)) & valid_v) == '0)
    else $error("gap in the cell row");

  // At most one cell is selected to leave.
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rm_sel))
    else $error("more than one leaving cell");

  // Every applied command leaves a result pending.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("applied command without result");

endmodule

FILE: rtl/vtq_cell.sv
// One slot of the sorted shift queue: holds a task, compares it, shifts it.
module vtq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtq_pkg::req_t        req,
  input  vtq_pkg::cell_ctrl_t  ctrl,
  input  vtq_pkg::entry_t      left_ent,
  input  vtq_pkg::entry_t      right_ent,
  output vtq_pkg::entry_t      ent,
  output vtq_pkg::cell_flags_t flags
);

  logic                 valid_r;
  vtq_pkg::id_t         id_r;
  vtq_pkg::key_t        tm_r;
  vtq_pkg::key_t        sq_r;
  logic                 cancel_r;
  vtq_pkg::key_t        dt;
  vtq_pkg::key_t        ds;
  vtq_pkg::cell_flags_t flags_nxt;
  vtq_pkg::cell_flags_t flags_r;

  assign ent   = '{valid: valid_r, id: id_r, tm: tm_r, sq: sq_r, cancel: cancel_r};
  assign flags = flags_r;

  // Wrap-aware order of the new key against this task.
  always_comb begin
    dt = req.tm - tm_r;
    ds = req.sq - sq_r;
    flags_nxt.lt    = valid_r & ((req.tm != tm_r) ? dt[vtq_pkg::KEY_W-1]
                                                  : ds[vtq_pkg::KEY_W-1]);
    flags_nxt.eq    = valid_r & (req.tm == tm_r) & (req.sq == sq_r);
    flags_nxt.match = valid_r & (req.id == id_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
      if (ctrl.load_new) begin
        valid_r  <= 1'b1;
        id_r     <= req.id;
        tm_r     <= req.tm;
        sq_r     <= req.sq;
        cancel_r <= 1'b0;
      end else if (ctrl.take_left) begin
        valid_r  <= left_ent.valid;
        id_r     <= left_ent.id;
        tm_r     <= left_ent.tm;
        sq_r     <= left_ent.sq;
        cancel_r <= left_ent.cancel;
      end else if (ctrl.take_right) begin
        valid_r  <= right_ent.valid;
        id_r     <= right_ent.id;
        tm_r     <= right_ent.tm;
        sq_r     <= right_ent.sq;
        cancel_r <= right_ent.cancel;
      end else if (ctrl.set_cancel && valid_r) begin
        cancel_r <= 1'b1;
      end
    end
  end

endmodule
